>>> hdl/usf_pkg.sv
// Package for the URL stream finder: byte class token, queue and back status and
// character class functions. No dependencies.
`default_nettype none

package usf_pkg;

   localparam int POSITION_BITS_DEFAULT = 16;
   localparam int QUEUE_DEPTH = 2;
   localparam int FIELD_BITS = 16;

   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;

   // One classified text byte, as it travels from the front to the back.
   typedef struct packed {
      logic is_letter;
      logic is_url;
      logic is_colon;
      logic is_slash;
      logic is_last;
   } token_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_stat_type;

   typedef struct packed {
      logic fire;
      logic last;
      logic pos_zero;
      logic url_open;
   } back_stat_type;

   function automatic logic letter_class(input logic [7:0] c);
      logic upper;
      logic lower;
      upper = (c >= 8'h41) && (c <= 8'h5A);
      lower = (c >= 8'h61) && (c <= 8'h7A);
      return upper || lower;
   endfunction

   function automatic logic url_class(input logic [7:0] c);
      logic hit;
      hit = letter_class(c) || ((c >= 8'h30) && (c <= 8'h39));
      case (c)
         8'h7E, 8'h3B, 8'h2F, 8'h3F, 8'h3A, 8'h40, 8'h3D, 8'h26,
         8'h24, 8'h2D, 8'h5F, 8'h2E, 8'h2B, 8'h21, 8'h2A,
         8'hC2, 8'hB4: hit = 1'b1;
         default: ;
      endcase
      return hit;
   endfunction

endpackage

`default_nettype wire

>>> hdl/usf_if.sv
// Channel interfaces of the URL stream finder: text byte in, URL span out.
// No dependencies.
`default_nettype none

interface usf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       is_last;
   modport source(output valid, output text_byte, output is_last, input ready);
   modport sink(input valid, input text_byte, input is_last, output ready);
endinterface

interface usf_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] url_first;
   logic [15:0] url_after;
   logic        position_overflow;
   modport source(output valid, output url_first, output url_after,
                  output position_overflow, input ready);
   modport sink(input valid, input url_first, input url_after,
                input position_overflow, output ready);
endinterface

`default_nettype wire

>>> hdl/usf_front.sv
// Front of the URL stream finder: accepts text bytes and classifies them.
// Depends on usf_pkg and usf_if.
`default_nettype none

module usf_front (
   usf_req_if.sink            req_chan,
   input  usf_pkg::queue_stat_type q_stat,
   output logic               push,
   output usf_pkg::token_type tok
);

   assign req_chan.ready = !q_stat.full;
   assign push           = req_chan.valid && !q_stat.full;

   always_comb begin
      tok.is_letter = usf_pkg::letter_class(req_chan.text_byte);
      tok.is_url    = usf_pkg::url_class(req_chan.text_byte);
      tok.is_colon  = (req_chan.text_byte == usf_pkg::CHAR_COLON);
      tok.is_slash  = (req_chan.text_byte == usf_pkg::CHAR_SLASH);
      tok.is_last   = req_chan.is_last;
   end

endmodule

`default_nettype wire

>>> hdl/usf_queue.sv
// Short token queue between front and back of the URL stream finder.
// Depends on usf_pkg.
`default_nettype none

module usf_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  usf_pkg::token_type      push_tok,
   input  logic                    pop,
   output usf_pkg::token_type      pop_tok,
   output usf_pkg::queue_stat_type q_stat
);

   localparam int DEPTH    = usf_pkg::QUEUE_DEPTH;
   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);
   localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(DEPTH - 1);
   localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(DEPTH);

   usf_pkg::token_type slot_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;

   assign q_stat.empty = (count_ff == '0);
   assign q_stat.full  = (count_ff == FULL_CNT);
   assign pop_tok      = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_tok;
      end
   end

endmodule

`default_nettype wire

>>> hdl/usf_back.sv
// Back of the URL stream finder: scanner state machine and result register.
// Depends on usf_pkg and usf_if.
`default_nettype none

module usf_back #(
   parameter int POSITION_BITS = usf_pkg::POSITION_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  usf_pkg::token_type     tok,
   input  usf_pkg::queue_stat_type q_stat,
   output logic                   pop,
   usf_rsp_if.source              rsp_chan,
   output usf_pkg::back_stat_type b_stat
);

   localparam int FB = usf_pkg::FIELD_BITS;
   localparam logic [1:0] STAGE_IDLE  = 2'd0;
   localparam logic [1:0] STAGE_COLON = 2'd1;
   localparam logic [1:0] STAGE_SLASH = 2'd2;

   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [POSITION_BITS-1:0] run_start_ff, run_start_in;
   logic [POSITION_BITS-1:0] cand_ff, cand_in;
   logic                     run_valid_ff, run_valid_in;
   logic [1:0]               stage_ff, stage_in;
   logic                     await_ff, await_in;
   logic                     in_url_ff, in_url_in;
   logic                     sat_ff, sat_in;

   logic                     out_valid_ff, out_valid_in;
   logic [FB-1:0]            out_first_ff, out_first_in;
   logic [FB-1:0]            out_after_ff, out_after_in;
   logic                     out_ovf_ff, out_ovf_in;

   logic                     fire;
   logic                     at_max;
   logic [POSITION_BITS-1:0] pos_next;
   logic                     sat_now;
   logic                     emit;
   logic [POSITION_BITS-1:0] emit_after;

   // Take a token only when the result register is free or being drained.
   assign fire = !q_stat.empty && (!out_valid_ff || rsp_chan.ready);
   assign pop  = fire;

   assign at_max   = &pos_ff;
   assign pos_next = at_max ? pos_ff : pos_ff + 1'b1;
   assign sat_now  = sat_ff || at_max;

   always_comb begin
      pos_in       = pos_ff;
      run_start_in = run_start_ff;
      cand_in      = cand_ff;
      run_valid_in = run_valid_ff;
      stage_in     = stage_ff;
      await_in     = await_ff;
      in_url_in    = in_url_ff;
      sat_in       = sat_ff;
      emit         = 1'b0;
      emit_after   = pos_ff;
      if (fire) begin
         if (in_url_ff || await_ff) begin
            if (tok.is_url) begin
               in_url_in  = 1'b1;
               await_in   = 1'b0;
               emit       = tok.is_last;
               emit_after = pos_next;
            end else begin
               emit         = in_url_ff;
               emit_after   = pos_ff;
               in_url_in    = 1'b0;
               await_in     = 1'b0;
               stage_in     = STAGE_IDLE;
               run_valid_in = 1'b0;
            end
         end else begin
            case (stage_ff)
               STAGE_COLON: begin
                  if (tok.is_slash) begin
                     stage_in = STAGE_SLASH;
                  end else if (tok.is_colon && run_valid_ff) begin
                     stage_in = STAGE_COLON;
                     cand_in  = run_start_ff;
                  end else begin
                     stage_in = STAGE_IDLE;
                  end
               end
               STAGE_SLASH: begin
                  if (tok.is_slash) begin
                     stage_in = STAGE_IDLE;
                     await_in = 1'b1;
                  end else if (tok.is_colon && run_valid_ff) begin
                     stage_in = STAGE_COLON;
                     cand_in  = run_start_ff;
                  end else begin
                     stage_in = STAGE_IDLE;
                  end
               end
               default: begin
                  if (tok.is_colon && run_valid_ff) begin
                     stage_in = STAGE_COLON;
                     cand_in  = run_start_ff;
                  end else begin
                     stage_in = STAGE_IDLE;
                  end
               end
            endcase
            if (tok.is_letter) begin
               if (!run_valid_ff) begin
                  run_start_in = pos_ff;
               end
               run_valid_in = 1'b1;
            end else begin
               run_valid_in = 1'b0;
            end
         end
         pos_in = pos_next;
         sat_in = sat_now;
         // Drop all scan state at the end of the text.
         if (tok.is_last) begin
            pos_in       = '0;
            run_start_in = '0;
            cand_in      = '0;
            run_valid_in = 1'b0;
            stage_in     = STAGE_IDLE;
            await_in     = 1'b0;
            in_url_in    = 1'b0;
            sat_in       = 1'b0;
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_first_in = out_first_ff;
      out_after_in = out_after_ff;
      out_ovf_in   = out_ovf_ff;
      if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
      if (emit) begin
         out_valid_in = 1'b1;
         out_first_in = FB'(cand_ff);
         out_after_in = FB'(emit_after);
         out_ovf_in   = sat_now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         run_start_ff <= '0;
         cand_ff      <= '0;
         run_valid_ff <= 1'b0;
         stage_ff     <= STAGE_IDLE;
         await_ff     <= 1'b0;
         in_url_ff    <= 1'b0;
         sat_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         run_start_ff <= run_start_in;
         cand_ff      <= cand_in;
         run_valid_ff <= run_valid_in;
         stage_ff     <= stage_in;
         await_ff     <= await_in;
         in_url_ff    <= in_url_in;
         sat_ff       <= sat_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_first_ff <= out_first_in;
      out_after_ff <= out_after_in;
      out_ovf_ff   <= out_ovf_in;
   end

   assign rsp_chan.valid             = out_valid_ff;
   assign rsp_chan.url_first         = out_first_ff;
   assign rsp_chan.url_after         = out_after_ff;
   assign rsp_chan.position_overflow = out_ovf_ff;

   assign b_stat.fire     = fire;
   assign b_stat.last     = tok.is_last;
   assign b_stat.pos_zero = (pos_ff == '0);
   assign b_stat.url_open = in_url_ff || await_ff;

endmodule

`default_nettype wire

>>> hdl/url_stream_finder.sv
// Top level of the URL stream finder: front classifier, token queue, back
// scanner. Depends on usf_pkg, usf_if, usf_front, usf_queue and usf_back.
//
//   channel    direction  word                          accepted when
//   req_chan   in         text_byte, is_last            valid && ready
//   rsp_chan   out        url_first, url_after, ovf     valid && ready
//
// One text byte per cycle sustained while results are taken; the result for
// the byte that closes the URL passes a queue slot, then the result register.
// The scanner updates its state once per byte, so the rate is set by
// that single state update in the back.
// Reset clears all scan state, the queue and the result valid.
// A stalled result holds the back; the two-entry queue fills, then req ready
// drops until the result is taken.
`default_nettype none

module url_stream_finder #(
   parameter int POSITION_BITS = usf_pkg::POSITION_BITS_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   usf_req_if.sink   req_chan,
   usf_rsp_if.source rsp_chan
);

   usf_pkg::token_type      push_tok;
   usf_pkg::token_type      pop_tok;
   usf_pkg::queue_stat_type q_stat;
   usf_pkg::back_stat_type  b_stat;
   logic                    push;
   logic                    pop;

   usf_front u_front (
      .req_chan (req_chan),
      .q_stat   (q_stat),
      .push     (push),
      .tok      (push_tok)
   );

   usf_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_tok (push_tok),
      .pop      (pop),
      .pop_tok  (pop_tok),
      .q_stat   (q_stat)
   );

   usf_back #(
      .POSITION_BITS (POSITION_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .tok      (pop_tok),
      .q_stat   (q_stat),
      .pop      (pop),
      .rsp_chan (rsp_chan),
      .b_stat   (b_stat)
   );

   a_fire_needs_token: assert property (@(posedge clock) disable iff (reset)
      b_stat.fire |-> !q_stat.empty)
      else $error("back consumed a token from an empty queue");

   a_last_clears_scan: assert property (@(posedge clock) disable iff (reset)
      (b_stat.fire && b_stat.last) |=> (b_stat.pos_zero && !b_stat.url_open))
      else $error("scan state not cleared after last byte");

   a_stall_holds_back: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.ready) |-> !b_stat.fire)
      else $error("back advanced while result register was stalled");

endmodule

`default_nettype wire
